FILE: rtl/cge_pkg.sv
package cge_pkg;

   // Request field widths
   localparam int CMD_W    = 3;
   localparam int NODE_W   = 6;
   localparam int AMOUNT_W = 16;

   // Response field widths
   localparam int STATUS_W = 2;
   localparam int RWEIGHT_W = 16;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD_NODE    = 3'd0,
      CMD_ADD_WEIGHT  = 3'd1,
      CMD_DEC_EDGE    = 3'd2,
      CMD_REMOVE_NODE = 3'd3,
      CMD_QUERY       = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_DONE    = 2'd0,
      STS_SKIPPED = 2'd1,
      STS_ABSENT  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EDGE_RD,
      ST_EDGE_UPD,
      ST_EDGE_WR2,
      ST_CLEAR,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

FILE: rtl/covisibility_graph_engine.sv
// Keyframe covisibility graph: a symmetric MAX_NODES x MAX_NODES matrix of WEIGHT_BITS-bit
// edge weights kept in one single-port-write, one-read synchronous memory (read data
// registered), plus one active flag per node in flip-flops. One request is processed at a
// time and every request yields one response. Add weight and decrement edge read the edge,
// modify it, write both directions and respond (no write when the decremented edge is
// absent); add node and remove node sweep the node's row and column through the single
// write port; query strongest reads the row one entry per cycle; rejected requests go
// straight to the response. A finished request waits for the output register to be free
// while the previous response is still held there with rsp_tready low.
// The matrix memory is not cleared after reset and needs no clearing pass:
// every edge command and query only touches entries of active nodes, and activating a node
// zeroes its whole row and column first, so reset-time contents are never observed.
// Node indices at or above MAX_NODES count as inactive. Response weight carries the low
// 16 bits of the stored weight.
module covisibility_graph_engine #(
   parameter int MAX_NODES   = 64,
   parameter int WEIGHT_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [2:0] command, [8:3] node_a, [14:9] node_b, [30:15] amount, [31] zero
   input  logic [cge_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [1:0] status, [7:2] neighbor, [8] neighbor_valid, [24:9] weight, [31:25] zero
   output logic [cge_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   localparam int NB       = $clog2(MAX_NODES);
   localparam int ADDR_W   = 2 * NB;
   localparam int DEPTH    = 1 << ADDR_W;
   localparam int SUM_W    = ((WEIGHT_BITS > cge_pkg::AMOUNT_W) ? WEIGHT_BITS
                                                              : cge_pkg::AMOUNT_W) + 1;
   localparam logic [WEIGHT_BITS-1:0] WMAX = {WEIGHT_BITS{1'b1}};
   localparam logic [NB:0] CNT_END = (NB+1)'(MAX_NODES);

   // Request fields
   logic [cge_pkg::CMD_W-1:0]    req_cmd;
   logic [cge_pkg::NODE_W-1:0]   req_a;
   logic [cge_pkg::NODE_W-1:0]   req_b;
   logic [cge_pkg::AMOUNT_W-1:0] req_amt;

   assign req_cmd = req_tdata[2:0];
   assign req_a   = req_tdata[8:3];
   assign req_b   = req_tdata[14:9];
   assign req_amt = req_tdata[30:15];

   // Weight memory
   logic [WEIGHT_BITS-1:0] mem [DEPTH];
   logic                   mem_we;
   logic [ADDR_W-1:0]      mem_waddr;
   logic [WEIGHT_BITS-1:0] mem_wdata;
   logic [ADDR_W-1:0]      mem_raddr;
   logic [WEIGHT_BITS-1:0] rd_data_ff;

   // Control and working registers
   cge_pkg::state_type     state_ff, state_in;
   logic [cge_pkg::CMD_W-1:0] cmd_ff, cmd_in;
   logic [NB-1:0]          a_ff, a_in;
   logic [NB-1:0]          b_ff, b_in;
   logic [cge_pkg::AMOUNT_W-1:0] amt_ff, amt_in;
   logic [NB:0]            cnt_ff, cnt_in;
   logic                   phase_ff, phase_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic [NB-1:0]          rd_col_ff, rd_col_in;
   logic [WEIGHT_BITS-1:0] best_ff, best_in;
   logic [NB-1:0]          nb_ff, nb_in;
   logic [cge_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [MAX_NODES-1:0]   mask_ff, mask_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [cge_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Request decode helpers
   logic [NB-1:0]   a_idx, b_idx;
   logic            a_range, b_range, a_on, b_on;
   logic [SUM_W-1:0] sum;
   logic            out_free;
   logic            nv;

   assign a_idx   = NB'(req_a);
   assign b_idx   = NB'(req_b);
   assign a_range = 32'(req_a) < 32'(MAX_NODES);
   assign b_range = 32'(req_b) < 32'(MAX_NODES);
   assign a_on    = a_range && mask_ff[a_idx];
   assign b_on    = b_range && mask_ff[b_idx];
   assign sum     = SUM_W'(rd_data_ff) + SUM_W'(amt_ff);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign nv      = (cmd_ff == cge_pkg::CMD_QUERY) && (status_ff == cge_pkg::STS_DONE)
                    && (best_ff != '0);

   assign req_tready = (state_ff == cge_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      amt_in       = amt_ff;
      cnt_in       = cnt_ff;
      phase_in     = phase_ff;
      rd_vld_in    = 1'b0;
      rd_col_in    = rd_col_ff;
      best_in      = best_ff;
      nb_in        = nb_ff;
      status_in    = status_ff;
      mask_in      = mask_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = {a_ff, b_ff};
      mem_wdata    = '0;
      mem_raddr    = {a_ff, b_ff};

      unique case (state_ff)
         cge_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in    = req_cmd;
               a_in      = a_idx;
               b_in      = b_idx;
               amt_in    = req_amt;
               cnt_in    = '0;
               phase_in  = 1'b0;
               best_in   = '0;
               nb_in     = '0;
               status_in = cge_pkg::STS_DONE;
               state_in  = cge_pkg::ST_FINISH;
               unique case (req_cmd)
                  cge_pkg::CMD_ADD_NODE: begin
                     if (a_range) state_in = cge_pkg::ST_CLEAR;
                     else status_in = cge_pkg::STS_SKIPPED;
                  end
                  cge_pkg::CMD_ADD_WEIGHT, cge_pkg::CMD_DEC_EDGE: begin
                     if (req_a == req_b || !a_on || !b_on) status_in = cge_pkg::STS_SKIPPED;
                     else state_in = cge_pkg::ST_EDGE_RD;
                  end
                  cge_pkg::CMD_REMOVE_NODE: begin
                     if (a_on) state_in = cge_pkg::ST_CLEAR;
                     else status_in = cge_pkg::STS_SKIPPED;
                  end
                  cge_pkg::CMD_QUERY: begin
                     if (a_on) state_in = cge_pkg::ST_SCAN;
                     else status_in = cge_pkg::STS_SKIPPED;
                  end
                  default: status_in = cge_pkg::STS_SKIPPED;
               endcase
            end
         end

         cge_pkg::ST_EDGE_RD: begin
            mem_raddr = {a_ff, b_ff};
            state_in  = cge_pkg::ST_EDGE_UPD;
         end

         cge_pkg::ST_EDGE_UPD: begin
            if (cmd_ff == cge_pkg::CMD_ADD_WEIGHT) begin
               best_in = (sum > SUM_W'(WMAX)) ? WMAX : WEIGHT_BITS'(sum);
            end else begin
               best_in = rd_data_ff - WEIGHT_BITS'(1);
            end
            if (cmd_ff == cge_pkg::CMD_DEC_EDGE && rd_data_ff == '0) begin
               // absent edge: leave the matrix alone
               best_in   = '0;
               status_in = cge_pkg::STS_ABSENT;
               state_in  = cge_pkg::ST_FINISH;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = {a_ff, b_ff};
               mem_wdata = best_in;
               state_in  = cge_pkg::ST_EDGE_WR2;
            end
         end

         cge_pkg::ST_EDGE_WR2: begin
            mem_we    = 1'b1;
            mem_waddr = {b_ff, a_ff};
            mem_wdata = best_ff;
            state_in  = cge_pkg::ST_FINISH;
         end

         cge_pkg::ST_CLEAR: begin
            if (cnt_ff == CNT_END) begin
               mask_in[a_ff] = (cmd_ff == cge_pkg::CMD_ADD_NODE);
               state_in      = cge_pkg::ST_FINISH;
            end else begin
               // zero row entry, then column entry, then advance
               mem_we    = 1'b1;
               mem_wdata = '0;
               mem_waddr = phase_ff ? {cnt_ff[NB-1:0], a_ff} : {a_ff, cnt_ff[NB-1:0]};
               phase_in  = !phase_ff;
               if (phase_ff) cnt_in = cnt_ff + (NB+1)'(1);
            end
         end

         cge_pkg::ST_SCAN: begin
            if (cnt_ff != CNT_END) begin
               mem_raddr = {a_ff, cnt_ff[NB-1:0]};
               rd_vld_in = 1'b1;
               rd_col_in = cnt_ff[NB-1:0];
               cnt_in    = cnt_ff + (NB+1)'(1);
            end
            if (rd_vld_ff && rd_col_ff != a_ff && rd_data_ff > best_ff) begin
               best_in = rd_data_ff;
               nb_in   = rd_col_ff;
            end
            if (cnt_ff == CNT_END && !rd_vld_ff) state_in = cge_pkg::ST_FINISH;
         end

         cge_pkg::ST_FINISH: begin
            // hold until the response register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in[1:0]  = status_ff;
               rsp_data_in[7:2]  = cge_pkg::NODE_W'(nb_ff);
               rsp_data_in[8]    = nv;
               rsp_data_in[24:9] = cge_pkg::RWEIGHT_W'(best_ff);
               state_in          = cge_pkg::ST_IDLE;
            end
         end

         default: state_in = cge_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cge_pkg::ST_IDLE;
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= rd_vld_in;
      end
      cmd_ff      <= cmd_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      amt_ff      <= amt_in;
      cnt_ff      <= cnt_in;
      phase_ff    <= phase_in;
      rd_col_ff   <= rd_col_in;
      best_ff     <= best_in;
      nb_ff       <= nb_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
